[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the channel table core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge outside reset.
`define SCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define SCT_ASSERT_NEVER(lbl, cond, msg) \
  `SCT_ASSERT(lbl, !(cond), msg)

`endif

[sv/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Operation and status codes, register indexes and shared types for the
// sequenced channel table.
// ----------------------------------------------------------------------------
package sct_pkg;

  typedef enum logic [2:0] {
    OP_OPEN    = 3'd0,
    OP_CLOSE   = 3'd1,
    OP_SEND    = 3'd2,
    OP_RECEIVE = 3'd3,
    OP_LOOKUP  = 3'd4
  } sct_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_RUNT     = 3'd3,
    ST_BACKWARD = 3'd4,
    ST_SKIP     = 3'd5
  } sct_status_e;

  typedef enum logic {
    CFG_MAX_PKT = 1'b0,
    CFG_OOO     = 1'b1
  } sct_cfg_e;

  localparam logic [15:0] MAX_PKT_RST   = 16'd1024;
  localparam logic [15:0] SEQ_HDR_BYTES = 16'd4;

  // Write enables into the slot store.
  typedef struct packed {
    logic word_we;  // handle / free link word plus end-of-list flag
    logic snd_we;   // send counter
    logic rcv_we;   // expected receive counter
  } sct_wr_t;

endpackage

[sv/sequenced_channel_table_core.sv]
// ----------------------------------------------------------------------------
// sequenced_channel_table_core
// Channel slot table with a free list threaded through the slots, send
// sequence stamping and receive sequence checking.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       to core    in_valid_i/in_stall_o   operation, slot, handle, length, rx_seq
//  out      from core  out_valid_o/out_stall_i status, accepted, slot_out, handle_out,
//                                               send_stamp, expected_seq, payload_len
//  cfg      to core    cfg_we_i                cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i is low; input register, then result register.
// The slot read-modify-write happens as a transaction leaves the input register.
// Reset is ready at once: slot reset values come from per-entry valid bits.
// out_stall_i backs up through the result register into in_stall_o.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequenced_channel_table_core #(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [2:0]  slot_i,
  input  logic [7:0]  handle_i,
  input  logic [15:0] length_i,
  input  logic [31:0] rx_seq_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        accepted_o,
  output logic [2:0]  slot_out_o,
  output logic [7:0]  handle_out_o,
  output logic [31:0] send_stamp_o,
  output logic [31:0] expected_seq_o,
  output logic [15:0] payload_len_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int SW = $clog2(SLOTS);

  typedef logic [255:0][SW-1:0] mod_tbl_t;

  // Slot index for every byte value, reduced modulo SLOTS at elaboration.
  function automatic mod_tbl_t mod_table();
    mod_tbl_t t;
    t = '0;
    for (int v = 0; v < 256; v++) t[8'(v)] = SW'(v % SLOTS);
    return t;
  endfunction

  localparam mod_tbl_t ModTbl = mod_table();

  function automatic logic [SW-1:0] mod_slots(input logic [7:0] v);
    return ModTbl[v];
  endfunction

  // config
  logic [15:0] max_pkt_q;
  logic        ooo_q;

  // input register
  logic        s1_v_q;
  logic [2:0]  op_q;
  logic [2:0]  slot_q;
  logic [7:0]  hnd_q;
  logic [15:0] len_q;
  logic [31:0] seq_q;

  // free list
  logic [SW-1:0] head_q, head_d;
  logic          full_q, full_d;

  // result register
  logic        out_v_q;
  logic [2:0]  status_q, status_d;
  logic        acc_q, acc_d;
  logic [2:0]  slot_o_q, slot_o_d;
  logic [7:0]  hnd_o_q, hnd_o_d;
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] expd_q, expd_d;
  logic [15:0] plen_q, plen_d;

  logic          out_free;
  logic          mv;
  logic          in_acc;
  logic          open_mv;
  logic          close_mv;
  logic [SW-1:0] ss;
  logic [SW-1:0] addr;
  sct_pkg::sct_wr_t wr;
  logic [7:0]    word_wr;
  logic          link_wr;
  logic [31:0]   snd_wr;
  logic [31:0]   rcv_wr;
  logic [7:0]    word_rd;
  logic          link_rd;
  logic [31:0]   snd_rd;
  logic [31:0]   rcv_rd;

  assign out_free   = !out_v_q || !out_stall_i;
  assign mv         = s1_v_q && out_free;
  assign in_stall_o = s1_v_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign open_mv    = mv && (op_q == sct_pkg::OP_OPEN);
  assign close_mv   = mv && (op_q == sct_pkg::OP_CLOSE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q <= sct_pkg::MAX_PKT_RST;
      ooo_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (sct_pkg::sct_cfg_e'(cfg_index_i))
        sct_pkg::CFG_MAX_PKT: max_pkt_q <= cfg_data_i;
        sct_pkg::CFG_OOO:     ooo_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (mv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      slot_q <= slot_i;
      hnd_q  <= handle_i;
      len_q  <= length_i;
      seq_q  <= rx_seq_i;
    end
  end

  assign ss   = mod_slots(8'(slot_q));
  assign addr = (op_q == sct_pkg::OP_OPEN) ? head_q : ss;

  sct_slot_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .addr_i     (addr),
    .wr_i       (wr),
    .word_i     (word_wr),
    .link_end_i (link_wr),
    .snd_i      (snd_wr),
    .rcv_i      (rcv_wr),
    .word_o     (word_rd),
    .link_end_o (link_rd),
    .snd_o      (snd_rd),
    .rcv_o      (rcv_rd)
  );

  always_comb begin
    head_d   = head_q;
    full_d   = full_q;
    wr       = '0;
    word_wr  = hnd_q;
    link_wr  = 1'b0;
    snd_wr   = 32'd0;
    rcv_wr   = 32'd0;
    status_d = sct_pkg::ST_OK;
    acc_d    = 1'b0;
    slot_o_d = 3'(ss);
    hnd_o_d  = 8'd0;
    stamp_d  = 32'd0;
    expd_d   = 32'd0;
    plen_d   = 16'd0;
    case (op_q)
      sct_pkg::OP_OPEN: begin
        if (full_q) begin
          status_d = sct_pkg::ST_FULL;
          slot_o_d = 3'd0;
        end else begin
          if (link_rd) full_d = 1'b1;
          else         head_d = mod_slots(word_rd);
          wr.word_we = 1'b1;
          wr.snd_we  = 1'b1;
          wr.rcv_we  = 1'b1;
          slot_o_d   = 3'(head_q);
          hnd_o_d    = hnd_q;
          acc_d      = 1'b1;
        end
      end
      sct_pkg::OP_CLOSE: begin
        hnd_o_d    = word_rd;
        word_wr    = 8'(head_q);
        link_wr    = full_q;
        wr.word_we = 1'b1;
        head_d     = ss;
        full_d     = 1'b0;
        acc_d      = 1'b1;
      end
      sct_pkg::OP_SEND: begin
        hnd_o_d = word_rd;
        if ((17'(len_q) + 17'(sct_pkg::SEQ_HDR_BYTES)) > 17'(max_pkt_q)) begin
          status_d = sct_pkg::ST_OVERSIZE;
        end else begin
          stamp_d   = snd_rd;
          snd_wr    = snd_rd + 32'd1;
          wr.snd_we = 1'b1;
          acc_d     = 1'b1;
        end
      end
      sct_pkg::OP_RECEIVE: begin
        hnd_o_d = word_rd;
        expd_d  = rcv_rd;
        if (len_q < sct_pkg::SEQ_HDR_BYTES) begin
          status_d = sct_pkg::ST_RUNT;
        end else begin
          if (seq_q < rcv_rd) begin
            status_d = sct_pkg::ST_BACKWARD;
            acc_d    = ooo_q;
          end else if (seq_q > rcv_rd) begin
            status_d = sct_pkg::ST_SKIP;
            acc_d    = ooo_q;
          end else begin
            acc_d = 1'b1;
          end
          rcv_wr    = seq_q + 32'd1;
          wr.rcv_we = 1'b1;
          if (acc_d) plen_d = len_q - sct_pkg::SEQ_HDR_BYTES;
        end
      end
      sct_pkg::OP_LOOKUP: begin
        hnd_o_d = word_rd;
        acc_d   = 1'b1;
      end
      default: ;
    endcase
    // nothing commits unless the transaction moves into the result register
    if (!mv) wr = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      full_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (mv) begin
        head_q <= head_d;
        full_q <= full_d;
      end
      if (out_free) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      status_q <= status_d;
      acc_q    <= acc_d;
      slot_o_q <= slot_o_d;
      hnd_o_q  <= hnd_o_d;
      stamp_q  <= stamp_d;
      expd_q   <= expd_d;
      plen_q   <= plen_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = status_q;
  assign accepted_o     = acc_q;
  assign slot_out_o     = slot_o_q;
  assign handle_out_o   = hnd_o_q;
  assign send_stamp_o   = stamp_q;
  assign expected_seq_o = expd_q;
  assign payload_len_o  = plen_q;

  `SCT_ASSERT(a_mv_fills_out, mv |=> out_v_q, "transaction lost on its way to the result")
  `SCT_ASSERT(a_open_full, open_mv && full_q |=> full_q && !acc_q, "open on a full table taken")
  `SCT_ASSERT(a_open_last, open_mv && !full_q && link_rd |=> full_q, "last slot not marked full")
  `SCT_ASSERT(a_close_head, close_mv |=> !full_q && head_q == $past(ss), "close not at list head")
  `SCT_ASSERT_NEVER(a_full_wr, open_mv && full_q && wr.word_we, "slot written on a full table")

endmodule

[sv/sct_slot_store.sv]
// ----------------------------------------------------------------------------
// sct_slot_store
// Per-slot storage: handle or free link word, end-of-list flag and the two
// sequence counters. Per-entry valid bits supply reset values until written.
// ----------------------------------------------------------------------------
module sct_slot_store #(
  parameter int SLOTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(SLOTS)-1:0] addr_i,
  input  sct_pkg::sct_wr_t         wr_i,
  input  logic [7:0]               word_i,
  input  logic                     link_end_i,
  input  logic [31:0]              snd_i,
  input  logic [31:0]              rcv_i,
  output logic [7:0]               word_o,
  output logic                     link_end_o,
  output logic [31:0]              snd_o,
  output logic [31:0]              rcv_o
);

  localparam int SW = $clog2(SLOTS);

  logic [7:0]       word_mem [SLOTS];
  logic             link_mem [SLOTS];
  logic [31:0]      snd_mem  [SLOTS];
  logic [31:0]      rcv_mem  [SLOTS];
  logic [SLOTS-1:0] word_vld_q;
  logic [SLOTS-1:0] snd_vld_q;
  logic [SLOTS-1:0] rcv_vld_q;
  logic [8:0]       nxt;
  logic [7:0]       word_rst;
  logic             link_rst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      snd_vld_q  <= '0;
      rcv_vld_q  <= '0;
    end else begin
      if (wr_i.word_we) word_vld_q[addr_i] <= 1'b1;
      if (wr_i.snd_we)  snd_vld_q[addr_i]  <= 1'b1;
      if (wr_i.rcv_we)  rcv_vld_q[addr_i]  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.word_we) begin
      word_mem[addr_i] <= word_i;
      link_mem[addr_i] <= link_end_i;
    end
    if (wr_i.snd_we) snd_mem[addr_i] <= snd_i;
    if (wr_i.rcv_we) rcv_mem[addr_i] <= rcv_i;
  end

  // Reset image: each free slot links to the next, the last one ends the list.
  always_comb begin
    nxt      = 9'(addr_i) + 9'd1;
    word_rst = (nxt < 9'(SLOTS)) ? nxt[7:0] : 8'd0;
    link_rst = (addr_i == SW'(SLOTS - 1));
  end

  assign word_o     = word_vld_q[addr_i] ? word_mem[addr_i] : word_rst;
  assign link_end_o = word_vld_q[addr_i] ? link_mem[addr_i] : link_rst;
  assign snd_o      = snd_vld_q[addr_i]  ? snd_mem[addr_i]  : 32'd0;
  assign rcv_o      = rcv_vld_q[addr_i]  ? rcv_mem[addr_i]  : 32'd0;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequenced_channel_table_core. A queue of pending
// transactions feeds a falling-edge driver; a rising-edge monitor predicts the
// result of every accepted transaction against a shadow slot table and checks
// each delivered result in order. Directed transactions cover the corner
// cases, then random phases under different register settings with random
// idle bursts, a long receiver hold-off and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import sct_pkg::*;

  localparam int SLOTS      = 8;
  localparam int CYCLE_CAP  = 300000;
  localparam int PHASE_REQS = 175;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [7:0]  handle;
    logic [15:0] length;
    logic [31:0] rx_seq;
  } chan_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        accepted;
    logic [2:0]  slot_out;
    logic [7:0]  handle_out;
    logic [31:0] send_stamp;
    logic [31:0] expected_seq;
    logic [15:0] payload_len;
  } chan_rsp_t;

  typedef struct packed {
    logic [SLOTS-1:0][7:0]  word;      // handle, or next-free link
    logic [SLOTS-1:0]       link_end;
    logic [SLOTS-1:0][31:0] snd;
    logic [SLOTS-1:0][31:0] rcv;
    logic [2:0]             head;
    logic                   full;
    logic [15:0]            max_bytes;
    logic                   ooo;
  } chan_table_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [2:0]  slot_i = '0;
  logic [7:0]  handle_i = '0;
  logic [15:0] length_i = '0;
  logic [31:0] rx_seq_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic        accepted_o;
  logic [2:0]  slot_out_o;
  logic [7:0]  handle_out_o;
  logic [31:0] send_stamp_o;
  logic [31:0] expected_seq_o;
  logic [15:0] payload_len_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  sequenced_channel_table_core #(.SLOTS(SLOTS)) uut (.*);

  chan_req_t   req_q[$];
  chan_rsp_t   due_rsp_q[$];
  chan_table_t check_tbl;   // advanced on accepted transactions
  chan_table_t gen_tbl;     // advanced as stimulus is queued
  logic [SLOTS-1:0] live;
  logic        in_took = 1'b0;
  logic        idle_en = 1'b1;
  logic        hold_req = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          cycles = 0;
  chan_rsp_t   got_rsp;
  chan_rsp_t   want_rsp;
  logic        rsp_bad;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic reset_table(output chan_table_t t);
    int i;
    t = '0;
    for (i = 0; i < SLOTS; i++) begin
      t.word[i] = (i + 1 < SLOTS) ? 8'(i + 1) : 8'd0;
      t.link_end[i] = (i + 1 == SLOTS);
    end
    t.max_bytes = MAX_PKT_RST;
  endtask

  task automatic channel_table_step(inout chan_table_t t, input chan_req_t rq,
                                    output chan_rsp_t rs);
    logic [2:0] a;
    logic [2:0] s;
    s = rq.slot;
    rs = '0;
    rs.slot_out = s;
    case (rq.op)
      OP_OPEN: begin
        if (t.full) begin
          rs.status = ST_FULL;
          rs.slot_out = '0;
        end else begin
          a = t.head;
          if (t.link_end[a]) t.full = 1'b1;
          else t.head = t.word[a][2:0];
          t.word[a] = rq.handle;
          t.link_end[a] = 1'b0;
          t.snd[a] = '0;
          t.rcv[a] = '0;
          rs.slot_out = a;
          rs.handle_out = rq.handle;
          rs.accepted = 1'b1;
        end
      end
      OP_CLOSE: begin
        rs.handle_out = t.word[s];
        t.word[s] = {5'd0, t.head};
        t.link_end[s] = t.full;
        t.head = s;
        t.full = 1'b0;
        rs.accepted = 1'b1;
      end
      OP_SEND: begin
        rs.handle_out = t.word[s];
        if (int'(rq.length) + int'(SEQ_HDR_BYTES) > int'(t.max_bytes)) begin
          rs.status = ST_OVERSIZE;
        end else begin
          rs.send_stamp = t.snd[s];
          t.snd[s] = t.snd[s] + 32'd1;
          rs.accepted = 1'b1;
        end
      end
      OP_RECEIVE: begin
        rs.handle_out = t.word[s];
        rs.expected_seq = t.rcv[s];
        if (rq.length < SEQ_HDR_BYTES) begin
          rs.status = ST_RUNT;
        end else begin
          if (rq.rx_seq < t.rcv[s]) begin
            rs.status = ST_BACKWARD;
            rs.accepted = t.ooo;
          end else if (rq.rx_seq > t.rcv[s]) begin
            rs.status = ST_SKIP;
            rs.accepted = t.ooo;
          end else begin
            rs.accepted = 1'b1;
          end
          // expected sequence follows the packet even when it is dropped
          t.rcv[s] = rq.rx_seq + 32'd1;
          if (rs.accepted) rs.payload_len = rq.length - SEQ_HDR_BYTES;
        end
      end
      OP_LOOKUP: begin
        rs.handle_out = t.word[s];
        rs.accepted = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic chan_req_t mk_req(logic [2:0] op, logic [2:0] s, logic [7:0] h,
                                       logic [15:0] len, logic [31:0] seq);
    return {op, s, h, len, seq};
  endfunction

  task automatic queue_req(input chan_req_t rq);
    chan_rsp_t rs;
    channel_table_step(gen_tbl, rq, rs);
    if (rq.op == OP_OPEN && rs.accepted) live[rs.slot_out] = 1'b1;
    if (rq.op == OP_CLOSE) live[rq.slot] = 1'b0;
    req_q.push_back(rq);
  endtask

  // Mostly operations on open slots with near-expected sequences; the rest
  // is noise: free slots, stray sequences, unused codes.
  task automatic queue_random_req();
    chan_req_t rq;
    int n_live;
    int p;
    int w_open;
    int w_close;
    logic [31:0] e;
    logic [2:0] s;
    n_live = $countones(live);
    s = 3'($urandom_range(0, SLOTS - 1));
    if (live != '0 && $urandom_range(0, 9) != 0)
      while (!live[s]) s = 3'($urandom_range(0, SLOTS - 1));
    w_open = (n_live < 3) ? 25 : (n_live > 6) ? 4 : 12;
    w_close = (n_live > 5) ? 15 : 6;
    rq = mk_req(OP_LOOKUP, s, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                $urandom());
    p = $urandom_range(0, 99);
    if (p < 3) begin
      rq.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end else if (p < 3 + w_open) begin
      rq.op = OP_OPEN;
    end else if (p < 3 + w_open + w_close) begin
      rq.op = OP_CLOSE;
    end else if (p < 10 + w_open + w_close) begin
      rq.op = OP_LOOKUP;
    end else if (p < 40 + w_open + w_close) begin
      rq.op = OP_SEND;
      if ($urandom_range(0, 7) == 0)
        rq.length = 16'(gen_tbl.max_bytes - $urandom_range(3, 4));
      else if ($urandom_range(0, 4) != 0)
        rq.length = 16'($urandom_range(0, gen_tbl.max_bytes - 4));
    end else begin
      rq.op = OP_RECEIVE;
      e = gen_tbl.rcv[s];
      p = $urandom_range(0, 99);
      if (p < 65) rq.rx_seq = e;
      else if (p < 75) rq.rx_seq = e - $urandom_range(1, 4);
      else if (p < 85) rq.rx_seq = e + $urandom_range(1, 4);
      if ($urandom_range(0, 11) == 0) rq.length = 16'($urandom_range(0, 3));
      else if ($urandom_range(0, 1) == 0) rq.length = 16'($urandom_range(4, 1500));
    end
    queue_req(rq);
  endtask

  // Returns at a falling edge once nothing is queued, offered or in flight.
  task automatic settle();
    @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || due_rsp_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input sct_cfg_e idx, input logic [15:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    if (idx == CFG_MAX_PKT) begin
      check_tbl.max_bytes = d;
      gen_tbl.max_bytes = d;
    end else begin
      check_tbl.ooo = d[0];
      gen_tbl.ooo = d[0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Driver: a new transaction is offered only once the last one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(0, 8);
        in_valid_i <= 1'b0;
      end else if (req_q.size() != 0) begin
        {operation_i, slot_i, handle_i, length_i, rx_seq_i} <= req_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result-side back-pressure; the long hold lets the core fill and stall.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 59;
      out_stall_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on input transactions, check output transactions.
  always @(posedge clk_i) begin
    in_took = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        channel_table_step(check_tbl, {operation_i, slot_i, handle_i, length_i, rx_seq_i},
                           want_rsp);
        due_rsp_q.push_back(want_rsp);
      end
      if (out_valid_o && !out_stall_i) begin
        got_rsp = {status_o, accepted_o, slot_out_o, handle_out_o, send_stamp_o,
                   expected_seq_o, payload_len_o};
        if (due_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: st=%0d acc=%0d slot=%0d hnd=%02h", got_rsp.status,
                     got_rsp.accepted, got_rsp.slot_out, got_rsp.handle_out);
        end else begin
          want_rsp = due_rsp_q.pop_front();
          rsp_bad = (got_rsp.status !== want_rsp.status) ||
                    (got_rsp.accepted !== want_rsp.accepted) ||
                    (got_rsp.slot_out !== want_rsp.slot_out) ||
                    (got_rsp.handle_out !== want_rsp.handle_out) ||
                    (got_rsp.send_stamp !== want_rsp.send_stamp) ||
                    (got_rsp.expected_seq !== want_rsp.expected_seq) ||
                    (got_rsp.payload_len !== want_rsp.payload_len);
          if (rsp_bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("expected st=%0d acc=%0d slot=%0d hnd=%02h stamp=%08h exp=%08h len=%0d",
                       want_rsp.status, want_rsp.accepted, want_rsp.slot_out,
                       want_rsp.handle_out, want_rsp.send_stamp, want_rsp.expected_seq,
                       want_rsp.payload_len);
              $display("actual   st=%0d acc=%0d slot=%0d hnd=%02h stamp=%08h exp=%08h len=%0d",
                       got_rsp.status, got_rsp.accepted, got_rsp.slot_out,
                       got_rsp.handle_out, got_rsp.send_stamp, got_rsp.expected_seq,
                       got_rsp.payload_len);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph;
    int i;
    logic [15:0] mx;
    logic oo;
    reset_table(check_tbl);
    reset_table(gen_tbl);
    live = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the table, then one more open hits table full
    queue_req(mk_req(OP_OPEN, 3'd0, 8'h00, 16'd0, 32'd0));
    queue_req(mk_req(OP_OPEN, 3'd7, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    for (i = 0; i < 6; i++) queue_req(mk_req(OP_OPEN, 3'(i), 8'(8'h11 * (i + 1)), 16'd0, 32'd0));
    queue_req(mk_req(OP_OPEN, 3'd0, 8'hA5, 16'd0, 32'd0));
    queue_req(mk_req(OP_SEND, 3'd0, 8'd0, 16'd1020, 32'd0));
    queue_req(mk_req(OP_SEND, 3'd0, 8'd0, 16'd1021, 32'd0));
    queue_req(mk_req(OP_SEND, 3'd7, 8'd0, 16'hFFFF, 32'd0));
    queue_req(mk_req(OP_RECEIVE, 3'd0, 8'd0, 16'd3, 32'd0));
    queue_req(mk_req(OP_RECEIVE, 3'd0, 8'd0, 16'd4, 32'd0));
    queue_req(mk_req(OP_RECEIVE, 3'd0, 8'd0, 16'hFFFF, 32'd7));
    queue_req(mk_req(OP_RECEIVE, 3'd0, 8'd0, 16'd100, 32'd2));
    // expected counter wraps to zero
    queue_req(mk_req(OP_RECEIVE, 3'd1, 8'd0, 16'd4, 32'hFFFF_FFFF));
    queue_req(mk_req(OP_RECEIVE, 3'd1, 8'd0, 16'd4, 32'd0));
    queue_req(mk_req(OP_LOOKUP, 3'd1, 8'd0, 16'd0, 32'd0));
    // double close leaves a self-linked free list
    queue_req(mk_req(OP_CLOSE, 3'd2, 8'd0, 16'd0, 32'd0));
    queue_req(mk_req(OP_CLOSE, 3'd2, 8'd0, 16'd0, 32'd0));
    queue_req(mk_req(OP_OPEN, 3'd0, 8'h77, 16'd0, 32'd0));
    queue_req(mk_req(OP_UNUSED_FIRST, 3'd7, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    queue_req(mk_req(OP_UNUSED_FIRST + 3'd1, 3'd5, 8'd0, 16'd0, 32'd0));
    queue_req(mk_req(OP_UNUSED_LAST, 3'd3, 8'd0, 16'd0, 32'd0));

    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin mx = 16'hFFFF; oo = 1'b1; end
        1: begin mx = 16'd4; oo = 1'b0; end
        2: begin mx = 16'($urandom_range(4, 2000)); oo = 1'b1; end
        3: begin mx = 16'($urandom_range(4, 65535)); oo = 1'b0; end
        4: begin mx = 16'd64; oo = 1'b1; end
        default: begin mx = 16'($urandom_range(4, 65535)); oo = 1'($urandom_range(0, 1)); end
      endcase
      write_reg(CFG_MAX_PKT, mx);
      write_reg(CFG_OOO, {15'd0, oo});
      idle_en = (ph != 3) && (ph != 5);
      if (ph == 1 || ph == 3) hold_req = 1'b1;
      for (i = 0; i < PHASE_REQS; i++) queue_random_req();
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && due_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sequenced_channel_table_core.f]
+incdir+sv
sv/sct_pkg.sv
sv/sct_slot_store.sv
sv/sequenced_channel_table_core.sv
test/tb_top.sv
